// ----- hw/rtl/dfalex_pkg.sv -----
// Lexer package: token codes, character classes and keyword ROM.
// Used by dfa_lexer_token_classifier; no dependencies.
package dfalex_pkg;

  localparam int MAX_TOKEN_LEN = 1023;
  localparam int KEYWORD_COUNT = 12;
  localparam int KW_ROM_DEPTH  = 12;
  localparam int KW_MAX        = 8;
  localparam int KW_USED       = (KEYWORD_COUNT < KW_ROM_DEPTH) ? KEYWORD_COUNT : KW_ROM_DEPTH;
  localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
  localparam int KW_IDX_W      = $clog2(KW_MAX);

  localparam logic [5:0] TK_ID       = 6'd0;
  localparam logic [5:0] TK_INT      = 6'd1;
  localparam logic [5:0] TK_FLOAT    = 6'd2;
  localparam logic [5:0] TK_STRING   = 6'd3;
  localparam logic [5:0] TK_KW_BASE  = 6'd4;
  localparam logic [5:0] TK_PLUS     = 6'd16;
  localparam logic [5:0] TK_ASSIGN   = 6'd17;
  localparam logic [5:0] TK_MINUS    = 6'd18;
  localparam logic [5:0] TK_SLASH    = 6'd19;
  localparam logic [5:0] TK_STAR     = 6'd20;
  localparam logic [5:0] TK_EQ       = 6'd21;
  localparam logic [5:0] TK_GE       = 6'd22;
  localparam logic [5:0] TK_GT       = 6'd23;
  localparam logic [5:0] TK_LE       = 6'd24;
  localparam logic [5:0] TK_LT       = 6'd25;
  localparam logic [5:0] TK_NE       = 6'd26;
  localparam logic [5:0] TK_LPAREN   = 6'd27;
  localparam logic [5:0] TK_RPAREN   = 6'd28;
  localparam logic [5:0] TK_LBRACKET = 6'd29;
  localparam logic [5:0] TK_RBRACKET = 6'd30;
  localparam logic [5:0] TK_LBRACE   = 6'd31;
  localparam logic [5:0] TK_RBRACE   = 6'd32;
  localparam logic [5:0] TK_COLON    = 6'd35;
  localparam logic [5:0] TK_SEMI     = 6'd36;
  localparam logic [5:0] TK_COMMA    = 6'd37;
  localparam logic [5:0] TK_NONE     = 6'd0;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  typedef logic [7:0] kw_word_t [KW_MAX];

  localparam kw_word_t KW_ROM [KW_ROM_DEPTH] = '{
    '{"i", "n", "t", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"f", "l", "o", "a", "t", 8'h0, 8'h0, 8'h0},
    '{"c", "h", "a", "r", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"i", "f", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"e", "l", "s", "e", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"f", "o", "r", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"w", "h", "i", "l", "e", 8'h0, 8'h0, 8'h0},
    '{"b", "r", "e", "a", "k", 8'h0, 8'h0, 8'h0},
    '{"c", "o", "n", "t", "i", "n", "u", "e"},
    '{"s", "t", "r", "u", "c", "t", 8'h0, 8'h0},
    '{"s", "w", "i", "t", "c", "h", 8'h0, 8'h0},
    '{"c", "a", "s", "e", 8'h0, 8'h0, 8'h0, 8'h0}
  };

  localparam logic [3:0] KW_LEN [KW_ROM_DEPTH] = '{
    4'd3, 4'd5, 4'd4, 4'd2, 4'd4, 4'd3, 4'd5, 4'd5, 4'd8, 4'd6, 4'd6, 4'd4
  };

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  // single-character operators and separators; TK_NONE otherwise
  function automatic logic [5:0] single_code(input logic [7:0] c);
    logic [5:0] code;
    unique case (c)
      "+":     code = TK_PLUS;
      "-":     code = TK_MINUS;
      "/":     code = TK_SLASH;
      "*":     code = TK_STAR;
      "(":     code = TK_LPAREN;
      ")":     code = TK_RPAREN;
      "[":     code = TK_LBRACKET;
      "]":     code = TK_RBRACKET;
      "{":     code = TK_LBRACE;
      "}":     code = TK_RBRACE;
      ":":     code = TK_COLON;
      ";":     code = TK_SEMI;
      ",":     code = TK_COMMA;
      default: code = TK_NONE;
    endcase
    return code;
  endfunction

endpackage

// ----- hw/rtl/dfa_lexer_token_classifier.sv -----
// Streaming lexer top level: character classifier, token state and keyword match.
// Depends on dfalex_pkg.
//
// Usage:
//   Input channel: in_valid / in_stall with in_kind and in_char_in. A word is taken
//   at a rising edge with in_valid high and in_stall low. in_kind 0 carries one
//   source byte; in_kind 1 marks end of input and flushes the pending token.
//   Result channel: out_valid / out_stall with out_token_code, out_token_length
//   and out_token_start. A token is emitted when the word after it arrives.
//   Output: the result is registered in the output register, or in the skid
//   register while a stalled result still holds the output register.
//   Throughput: one word per cycle while in_stall is low; the lexer state, keyword
//   compare and result select all sit between the state and output registers.
//   A two-entry output (output register plus skid register) lets the block keep
//   taking words while one result waits; in_stall rises only while the skid
//   register is full, that is while a stalled result waits with a second behind it.
//   Reset: rst_n low at a rising edge returns the lexer to its start state,
//   clears the stream offset and empties both output entries.
module dfa_lexer_token_classifier
  import dfalex_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_char_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_token_code,
  output logic [9:0]  out_token_length,
  output logic [31:0] out_token_start
);

  typedef enum logic [3:0] {
    ST_START, ST_ID, ST_INT, ST_FLOAT, ST_DONE,
    ST_EQ1, ST_BANG, ST_GT1, ST_LT1, ST_STR
  } lex_state_t;

  lex_state_t       state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       first_r, first_nxt;
  logic [31:0]      pos_r, pos_nxt;
  logic [31:0]      start_r, start_nxt;
  logic [7:0]       kwbuf_r [KW_MAX];
  logic [7:0]       kwbuf_nxt [KW_MAX];

  logic             accept;
  logic             emit;
  logic [5:0]       pend_code;
  logic             pend_ok;
  logic [5:0]       kw_code;
  logic             can_extend;
  logic             restart;

  logic             out_valid_r;
  logic [5:0]       out_code_r;
  logic [9:0]       out_len_r;
  logic [31:0]      out_start_r;
  logic             skid_valid_r;
  logic [5:0]       skid_code_r;
  logic [9:0]       skid_len_r;
  logic [31:0]      skid_start_r;
  logic             pop;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid_r && !out_stall;

  // keyword match, first hit in list order
  always_comb begin
    logic hit;
    logic found;
    kw_code = TK_ID;
    found   = 1'b0;
    for (int i = 0; i < KW_USED; i++) begin
      hit = (len_r == LEN_W'(KW_LEN[i]));
      for (int j = 0; j < KW_MAX; j++) begin
        if ((4'(j) < KW_LEN[i]) && (kwbuf_r[j] != KW_ROM[i][j])) begin
          hit = 1'b0;
        end
      end
      if (hit && !found) begin
        kw_code = TK_KW_BASE + 6'(i);
        found   = 1'b1;
      end
    end
  end

  always_comb begin
    pend_ok   = 1'b1;
    pend_code = TK_NONE;
    unique case (state_r)
      ST_ID:    pend_code = kw_code;
      ST_INT:   pend_code = TK_INT;
      ST_FLOAT: pend_code = TK_FLOAT;
      ST_EQ1:   pend_code = TK_ASSIGN;
      ST_GT1:   pend_code = TK_GT;
      ST_LT1:   pend_code = TK_LT;
      ST_DONE: begin
        priority if (first_r == CH_QUOTE) pend_code = TK_STRING;
        else if (first_r == CH_EQUALS)    pend_code = TK_EQ;
        else if (first_r == CH_BANG)      pend_code = TK_NE;
        else if (first_r == CH_GT)        pend_code = TK_GE;
        else if (first_r == CH_LT)        pend_code = TK_LE;
        else                              pend_code = single_code(first_r);
      end
      default:  pend_ok = 1'b0;
    endcase
  end

  assign can_extend = (len_r < LEN_W'(MAX_TOKEN_LEN));

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    first_nxt = first_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    for (int j = 0; j < KW_MAX; j++) kwbuf_nxt[j] = kwbuf_r[j];
    emit    = 1'b0;
    restart = 1'b0;

    if (in_kind) begin
      emit      = pend_ok;
      state_nxt = ST_START;
    end else begin
      pos_nxt = pos_r + 32'd1;
      unique case (state_r)
        ST_ID: begin
          if (is_letter(in_char_in) || is_digit(in_char_in)) begin
            restart = !can_extend;
          end else begin
            emit    = 1'b1;
            restart = 1'b1;
          end
        end
        ST_INT: begin
          if (is_digit(in_char_in)) begin
            restart = !can_extend;
          end else if (in_char_in == CH_DOT) begin
            restart = !can_extend;
            if (can_extend) state_nxt = ST_FLOAT;
          end else begin
            emit    = 1'b1;
            restart = 1'b1;
          end
        end
        ST_FLOAT: begin
          if (is_digit(in_char_in)) begin
            restart = !can_extend;
          end else begin
            emit    = 1'b1;
            restart = 1'b1;
          end
        end
        ST_EQ1, ST_GT1, ST_LT1: begin
          if (in_char_in == CH_EQUALS) begin
            restart = !can_extend;
            if (can_extend) state_nxt = ST_DONE;
          end else begin
            emit    = 1'b1;
            restart = 1'b1;
          end
        end
        ST_BANG: begin
          if (in_char_in == CH_EQUALS) begin
            restart = !can_extend;
            if (can_extend) state_nxt = ST_DONE;
          end else begin
            restart = 1'b1;
          end
        end
        ST_STR: begin
          restart = !can_extend;
          if (can_extend && (in_char_in == CH_QUOTE)) state_nxt = ST_DONE;
        end
        ST_DONE: begin
          emit    = 1'b1;
          restart = 1'b1;
        end
        default: restart = 1'b1;
      endcase

      // append to the pending token
      if (!restart) begin
        if ((state_r == ST_ID) && (len_r < LEN_W'(KW_MAX))) begin
          kwbuf_nxt[len_r[KW_IDX_W-1:0]] = in_char_in;
        end
        len_nxt = len_r + LEN_W'(1);
      end

      // start a new token with this byte
      if (restart) begin
        state_nxt = ST_START;
        if (!is_blank(in_char_in)) begin
          priority if (is_letter(in_char_in))         state_nxt = ST_ID;
          else if (is_digit(in_char_in))              state_nxt = ST_INT;
          else if (single_code(in_char_in) != TK_NONE) state_nxt = ST_DONE;
          else if (in_char_in == CH_EQUALS)           state_nxt = ST_EQ1;
          else if (in_char_in == CH_BANG)             state_nxt = ST_BANG;
          else if (in_char_in == CH_GT)               state_nxt = ST_GT1;
          else if (in_char_in == CH_LT)               state_nxt = ST_LT1;
          else if (in_char_in == CH_QUOTE)            state_nxt = ST_STR;
          else                                        state_nxt = ST_START;
        end
        if (state_nxt != ST_START) begin
          len_nxt      = LEN_W'(1);
          first_nxt    = in_char_in;
          start_nxt    = pos_r;
          kwbuf_nxt[0] = in_char_in;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
      len_r   <= '0;
      first_r <= '0;
      pos_r   <= '0;
      start_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      first_r <= first_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < KW_MAX; j++) kwbuf_r[j] <= kwbuf_nxt[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (accept && emit) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_code_r  <= skid_code_r;
        out_len_r   <= skid_len_r;
        out_start_r <= skid_start_r;
      end
    end else if (accept && emit) begin
      if (!out_valid_r || pop) begin
        out_code_r  <= pend_code;
        out_len_r   <= 10'(len_r);
        out_start_r <= start_r;
      end else begin
        skid_code_r  <= pend_code;
        skid_len_r   <= 10'(len_r);
        skid_start_r <= start_r;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_token_code   = out_code_r;
  assign out_token_length = out_len_r;
  assign out_token_start  = out_start_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without output entry");

  a_eoi_to_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind) |=> (state_r == ST_START))
    else $error("end of input left lexer outside start state");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_TOKEN_LEN))
    else $error("token length above limit");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_code_r)))
    else $error("stalled result lost");

endmodule
